>>> design/rmq_pkg.sv
// rmq_pkg: shared types and constants for the rotation matrix to quaternion block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rmq_pkg;

	// Width of every matrix element and quaternion component
	localparam int FIELD_W = 18;
	// Width of a sum or difference of two elements
	localparam int D_W = FIELD_W + 1;
	// Default fraction bits and front-to-back queue depth
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

	// Classification handed from front to back
	typedef struct packed {
		branch_t branch;
		logic    bad;
	} cls_t;

	localparam int CLS_W = $bits(cls_t);

endpackage

>>> design/rmq_front.sv
// rmq_front: classifies one matrix; picks the branch, forms the root argument
// and the three off-diagonal sums or differences. Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_front import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic signed [FIELD_W-1:0] e00,
	input  logic signed [FIELD_W-1:0] e01,
	input  logic signed [FIELD_W-1:0] e02,
	input  logic signed [FIELD_W-1:0] e10,
	input  logic signed [FIELD_W-1:0] e11,
	input  logic signed [FIELD_W-1:0] e12,
	input  logic signed [FIELD_W-1:0] e20,
	input  logic signed [FIELD_W-1:0] e21,
	input  logic signed [FIELD_W-1:0] e22,
	output logic [((FRAC_BITS > D_W) ? FRAC_BITS : D_W):0] arg_mag,
	output logic signed [D_W-1:0] d1,
	output logic signed [D_W-1:0] d2,
	output logic signed [D_W-1:0] d3,
	output cls_t cls
);

	localparam int ARG_W = ((FRAC_BITS > D_W) ? FRAC_BITS : D_W) + 2;
	localparam logic signed [ARG_W-1:0] ONE = ARG_W'(1) << FRAC_BITS;

	function automatic logic signed [ARG_W-1:0] ext(input logic signed [FIELD_W-1:0] v);
		return {{(ARG_W-FIELD_W){v[FIELD_W-1]}}, v};
	endfunction

	function automatic logic signed [D_W-1:0] add2(input logic signed [FIELD_W-1:0] a,
			input logic signed [FIELD_W-1:0] b);
		return {a[FIELD_W-1], a} + {b[FIELD_W-1], b};
	endfunction

	function automatic logic signed [D_W-1:0] sub2(input logic signed [FIELD_W-1:0] a,
			input logic signed [FIELD_W-1:0] b);
		return {a[FIELD_W-1], a} - {b[FIELD_W-1], b};
	endfunction

	logic signed [ARG_W-1:0] trace;
	logic signed [ARG_W-1:0] arg;

	// Branch choice; ties fall to the later branch
	always_comb begin
		trace = ext(e00) + ext(e11) + ext(e22);
		if (!trace[ARG_W-1]) begin
			cls.branch = BR_TRACE;
			arg = trace + ONE;
			d1 = sub2(e21, e12);
			d2 = sub2(e02, e20);
			d3 = sub2(e10, e01);
		end else if (e00 > e11 && e00 > e22) begin
			cls.branch = BR_X;
			arg = ONE + ext(e00) - ext(e11) - ext(e22);
			d1 = add2(e10, e01);
			d2 = add2(e02, e20);
			d3 = sub2(e21, e12);
		end else if (e11 > e22) begin
			cls.branch = BR_Y;
			arg = ONE + ext(e11) - ext(e00) - ext(e22);
			d1 = add2(e10, e01);
			d2 = add2(e21, e12);
			d3 = sub2(e02, e20);
		end else begin
			cls.branch = BR_Z;
			arg = ONE + ext(e22) - ext(e00) - ext(e11);
			d1 = add2(e02, e20);
			d2 = add2(e21, e12);
			d3 = sub2(e10, e01);
		end
		cls.bad = arg[ARG_W-1] || (arg == '0);
		arg_mag = arg[ARG_W-2:0];
	end

endmodule

>>> design/rmq_queue.sv
// rmq_queue: short FIFO between the classifying front and the arithmetic back.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_queue import rmq_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [0:DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// Storage, no reset
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> design/rmq_div_pipe.sv
// rmq_div_pipe: pipelined restoring divider, one quotient bit per stage,
// sign carried alongside. Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_div_pipe import rmq_pkg::*; #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 18
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic             neg,
	output logic [NUM_W-1:0] quo,
	output logic             quo_neg
);

	logic [NUM_W-1:0] num_s [0:NUM_W-1];
	logic [DEN_W-1:0] den_s [0:NUM_W-1];
	logic [DEN_W-1:0] rem_s [0:NUM_W-1];
	logic [NUM_W-1:0] quo_s [0:NUM_W-1];
	logic             neg_s [0:NUM_W-1];

	for (genvar k = 0; k < NUM_W; k++) begin : g_st
		logic [NUM_W-1:0] num_in;
		logic [DEN_W-1:0] den_in;
		logic [DEN_W-1:0] rem_in;
		logic [NUM_W-1:0] quo_in;
		logic             neg_in;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign num_in = num;
			assign den_in = den;
			assign rem_in = '0;
			assign quo_in = '0;
			assign neg_in = neg;
		end else begin : g_next
			assign num_in = num_s[k-1];
			assign den_in = den_s[k-1];
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign neg_in = neg_s[k-1];
		end

		// Shift in the next dividend bit, subtract when it fits
		assign trial = {rem_in, num_in[NUM_W-1-k]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = (trial >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k] <= num_in;
				den_s[k] <= den_in;
				neg_s[k] <= neg_in;
				rem_s[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_s[k] <= {quo_in[NUM_W-2:0], ge};
			end
		end
	end

	assign quo     = quo_s[NUM_W-1];
	assign quo_neg = neg_s[NUM_W-1];

endmodule

>>> design/rmq_back.sv
// rmq_back: square root pipeline, three dividers, saturation and the output
// register. Depends on rmq_pkg and rmq_div_pipe.
`timescale 1ns / 1ps

module rmq_back import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// queue head
	input  logic                  head_valid,
	input  logic [((FRAC_BITS > D_W) ? FRAC_BITS : D_W):0] head_arg,
	input  logic signed [D_W-1:0] head_d1,
	input  logic signed [D_W-1:0] head_d2,
	input  logic signed [D_W-1:0] head_d3,
	input  cls_t                  head_cls,
	output logic                  pop,
	// result side
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [FIELD_W-1:0] quat_w,
	output logic signed [FIELD_W-1:0] quat_x,
	output logic signed [FIELD_W-1:0] quat_y,
	output logic signed [FIELD_W-1:0] quat_z,
	output branch_t               branch_taken,
	output logic                  not_rotation
);

	localparam int UARG_W = ((FRAC_BITS > D_W) ? FRAC_BITS : D_W) + 1;
	localparam int SQ_W   = (UARG_W + FRAC_BITS + 1) / 2;
	localparam int RAD_W  = 2 * SQ_W;
	localparam int REM_W  = SQ_W + 3;
	localparam int DV_W   = D_W + FRAC_BITS - 1;
	localparam int SB_W   = 3 * D_W + CLS_W;
	localparam logic signed [FIELD_W-1:0] SAT_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic signed [FIELD_W-1:0] SAT_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

	logic en;
	logic out_valid_q;

	// Whole back pipeline advances unless a result is stuck in the output register
	assign en        = !out_valid_q || out_ready;
	assign pop       = en && head_valid;
	assign out_valid = out_valid_q;

	// ---------------- square root, one root bit per stage ----------------
	logic [RAD_W-1:0] rad0;
	logic [RAD_W-1:0] sq_rad_s  [0:SQ_W-1];
	logic [REM_W-1:0] sq_rem_s  [0:SQ_W-1];
	logic [SQ_W-1:0]  sq_root_s [0:SQ_W-1];
	logic [SB_W-1:0]  sq_side_s [0:SQ_W-1];
	logic             sq_valid_s [0:SQ_W-1];

	assign rad0 = RAD_W'({head_arg, {FRAC_BITS{1'b0}}});

	for (genvar k = 0; k < SQ_W; k++) begin : g_sq
		logic [RAD_W-1:0] rad_in;
		logic [REM_W-1:0] rem_in;
		logic [SQ_W-1:0]  root_in;
		logic [SB_W-1:0]  side_in;
		logic             valid_in;
		logic [REM_W-1:0] trial;
		logic [REM_W-1:0] test;
		logic             ge;

		if (k == 0) begin : g_first
			assign rad_in   = rad0;
			assign rem_in   = '0;
			assign root_in  = '0;
			assign side_in  = {head_d1, head_d2, head_d3, head_cls};
			assign valid_in = head_valid;
		end else begin : g_next
			assign rad_in   = sq_rad_s[k-1];
			assign rem_in   = sq_rem_s[k-1];
			assign root_in  = sq_root_s[k-1];
			assign side_in  = sq_side_s[k-1];
			assign valid_in = sq_valid_s[k-1];
		end

		assign trial = {rem_in[REM_W-3:0], rad_in[RAD_W-1-2*k -: 2]};
		assign test  = REM_W'({root_in, 2'b01});
		assign ge    = (trial >= test);

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_s[k]  <= rad_in;
				sq_side_s[k] <= side_in;
				sq_rem_s[k]  <= ge ? trial - test : trial;
				sq_root_s[k] <= {root_in[SQ_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_valid_s[k] <= 1'b0;
			end else if (en) begin
				sq_valid_s[k] <= valid_in;
			end
		end
	end

	// ---------------- off-diagonal scaling: d * 2^(F-1) / s ----------------
	logic [SQ_W-1:0]          s_root;
	logic signed [D_W-1:0]    sd1, sd2, sd3;
	cls_t                     s_cls;
	logic [D_W-1:0]           mag1, mag2, mag3;
	logic [DV_W-1:0]          q1, q2, q3;
	logic                     n1, n2, n3;

	assign s_root = sq_root_s[SQ_W-1];
	assign {sd1, sd2, sd3, s_cls} = sq_side_s[SQ_W-1];
	assign mag1 = sd1[D_W-1] ? D_W'(-sd1) : D_W'(sd1);
	assign mag2 = sd2[D_W-1] ? D_W'(-sd2) : D_W'(sd2);
	assign mag3 = sd3[D_W-1] ? D_W'(-sd3) : D_W'(sd3);

	rmq_div_pipe #(.NUM_W(DV_W), .DEN_W(SQ_W)) u_div1 (
		.clk(clk), .en(en), .num(DV_W'({mag1, {(FRAC_BITS-1){1'b0}}})), .den(s_root),
		.neg(sd1[D_W-1]), .quo(q1), .quo_neg(n1)
	);
	rmq_div_pipe #(.NUM_W(DV_W), .DEN_W(SQ_W)) u_div2 (
		.clk(clk), .en(en), .num(DV_W'({mag2, {(FRAC_BITS-1){1'b0}}})), .den(s_root),
		.neg(sd2[D_W-1]), .quo(q2), .quo_neg(n2)
	);
	rmq_div_pipe #(.NUM_W(DV_W), .DEN_W(SQ_W)) u_div3 (
		.clk(clk), .en(en), .num(DV_W'({mag3, {(FRAC_BITS-1){1'b0}}})), .den(s_root),
		.neg(sd3[D_W-1]), .quo(q3), .quo_neg(n3)
	);

	// Diagonal term and class travel beside the dividers
	logic [SQ_W-2:0] dv_diag_s [0:DV_W-1];
	cls_t            dv_cls_s  [0:DV_W-1];
	logic            dv_valid_s [0:DV_W-1];

	for (genvar j = 0; j < DV_W; j++) begin : g_dv
		always_ff @(posedge clk) begin
			if (en) begin
				dv_diag_s[j] <= (j == 0) ? s_root[SQ_W-1:1] : dv_diag_s[(j == 0) ? 0 : j-1];
				dv_cls_s[j]  <= (j == 0) ? s_cls : dv_cls_s[(j == 0) ? 0 : j-1];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_valid_s[j] <= 1'b0;
			end else if (en) begin
				dv_valid_s[j] <= (j == 0) ? sq_valid_s[SQ_W-1] : dv_valid_s[(j == 0) ? 0 : j-1];
			end
		end
	end

	// ---------------- saturation and component placement ----------------
	function automatic logic signed [FIELD_W-1:0] sat_off(input logic ng,
			input logic [DV_W-1:0] q);
		logic signed [FIELD_W-1:0] r;
		if (ng) begin
			r = (q > DV_W'(1) << (FIELD_W-1)) ? SAT_MIN : -FIELD_W'(q);
		end else begin
			r = (q > DV_W'(SAT_MAX)) ? SAT_MAX : FIELD_W'(q);
		end
		return r;
	endfunction

	logic signed [FIELD_W-1:0] o1, o2, o3, dg;
	logic [SQ_W-2:0]           diag_l;
	cls_t                      cls_l;
	logic signed [FIELD_W-1:0] nw, nx, ny, nz;

	assign diag_l = dv_diag_s[DV_W-1];
	assign cls_l  = dv_cls_s[DV_W-1];
	assign o1 = sat_off(n1, q1);
	assign o2 = sat_off(n2, q2);
	assign o3 = sat_off(n3, q3);
	assign dg = ((SQ_W-1) >= FIELD_W && (SQ_W + FIELD_W)'(diag_l) > (SQ_W + FIELD_W)'(SAT_MAX))
		? SAT_MAX : FIELD_W'(diag_l);

	always_comb begin
		case (cls_l.branch)
			BR_TRACE: begin nw = dg; nx = o1; ny = o2; nz = o3; end
			BR_X:     begin nx = dg; ny = o1; nz = o2; nw = o3; end
			BR_Y:     begin ny = dg; nx = o1; nz = o2; nw = o3; end
			default:  begin nz = dg; nx = o1; ny = o2; nw = o3; end
		endcase
		if (cls_l.bad) begin
			nw = '0;
			nx = '0;
			ny = '0;
			nz = '0;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			quat_w       <= nw;
			quat_x       <= nx;
			quat_y       <= ny;
			quat_z       <= nz;
			branch_taken <= cls_l.branch;
			not_rotation <= cls_l.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid_s[DV_W-1];
		end
	end

	// A rejected matrix always comes out as all zeros
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && not_rotation |-> quat_w == '0 && quat_x == '0 && quat_y == '0
			&& quat_z == '0)
		else $error("non-rotation result not zeroed");

	// The trace branch never rejects its argument
	a_trace_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && branch_taken == BR_TRACE |-> !not_rotation)
		else $error("trace branch flagged as non-rotation");

	// The diagonal term is a root and so never negative
	a_trace_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && branch_taken == BR_TRACE |-> !quat_w[FIELD_W-1])
		else $error("negative w in trace branch");

	// Queue is drained only while the pipeline moves
	a_pop_en: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> en && head_valid)
		else $error("queue popped while stalled");

endmodule

>>> design/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to quaternion (trace method), fixed point, streaming.
// Path: queue, R root stages, then Q = FRAC_BITS + 18 quotient stages, output register;
// 18 root and 34 quotient stages at FRAC_BITS = 16. One matrix per cycle unless
// m_axis_tready stalls the output; set by the fully pipelined root and divider stages.
// Reset: arst_n asynchronous, active low; clears queue and valid bits, no clearing pass.
// Depends on rmq_pkg, rmq_front, rmq_queue, rmq_back.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// e00, e01, e02, e10, e11, e12, e20, e21, e22 (18 bits each), 6 zero bits
	input  logic [167:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// quat_w, quat_x, quat_y, quat_z (18 bits each)
	output logic [71:0]  m_axis_tdata,
	// branch_taken (2 bits), not_rotation (1 bit)
	output logic [2:0]   m_axis_tuser
);

	localparam int UARG_W = ((FRAC_BITS > D_W) ? FRAC_BITS : D_W) + 1;
	localparam int QW     = UARG_W + 3 * D_W + CLS_W;

	logic [UARG_W-1:0]     f_arg, h_arg;
	logic signed [D_W-1:0] f_d1, f_d2, f_d3, h_d1, h_d2, h_d3;
	cls_t                  f_cls, h_cls;
	logic [QW-1:0]         q_din, q_dout;
	logic                  q_full, q_empty, q_pop;
	logic signed [FIELD_W-1:0] qw, qx, qy, qz;
	branch_t               br;
	logic                  nr;

	rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.e00(s_axis_tdata[17:0]),    .e01(s_axis_tdata[35:18]),
		.e02(s_axis_tdata[53:36]),   .e10(s_axis_tdata[71:54]),
		.e11(s_axis_tdata[89:72]),   .e12(s_axis_tdata[107:90]),
		.e20(s_axis_tdata[125:108]), .e21(s_axis_tdata[143:126]),
		.e22(s_axis_tdata[161:144]),
		.arg_mag(f_arg), .d1(f_d1), .d2(f_d2), .d3(f_d3), .cls(f_cls)
	);

	assign s_axis_tready = !q_full;
	assign q_din = {f_arg, f_d1, f_d2, f_d3, f_cls};

	rmq_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(s_axis_tvalid), .din(q_din), .full(q_full),
		.pop(q_pop), .dout(q_dout), .empty(q_empty)
	);

	assign {h_arg, h_d1, h_d2, h_d3, h_cls} = q_dout;

	rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.head_valid(!q_empty), .head_arg(h_arg),
		.head_d1(h_d1), .head_d2(h_d2), .head_d3(h_d3), .head_cls(h_cls),
		.pop(q_pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.quat_w(qw), .quat_x(qx), .quat_y(qy), .quat_z(qz),
		.branch_taken(br), .not_rotation(nr)
	);

	assign m_axis_tdata = {qz, qy, qx, qw};
	assign m_axis_tuser = {nr, br};

endmodule
